// ----- rtl/sgsu_pkg.sv -----
// Shared constants, types and the threshold ROM builder for the gene site update block.
package sgsu_pkg;

    // Generator rows by default
    localparam int ROWS_DEFAULT = 128;

    // Field widths
    localparam int OP_W       = 2;
    localparam int ROW_IN_W   = 7;
    localparam int ROW_IN_N   = 2 ** ROW_IN_W;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int ALIVE_W    = 2;
    localparam int CNT_W      = 6;
    localparam int ROM_SIZE   = HALF_W + 1;

    // Opcodes
    localparam logic [OP_W-1:0] OP_WR_W0  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_W1  = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

    // xorshift128+ shift amounts
    localparam int SH_A = 23;
    localparam int SH_B = 17;
    localparam int SH_C = 26;

    typedef logic [ROM_SIZE-1:0][HALF_W-1:0] t_thr_rom;

    // Survival thresholds floor((2^32-1) * exp(-n)), fixed point throughout.
    function automatic t_thr_rom build_thr_rom();
        logic [63:0]  term;
        logic [63:0]  e1;
        logic [63:0]  f;
        logic [63:0]  t;
        logic [127:0] prod;
        t_thr_rom     rom;
        // exp(-1) as a Q0.64 fraction, truncated series
        term = 64'h8000_0000_0000_0000;
        e1   = term;
        for (int k = 3; k <= 25; k++) begin
            term = term / 64'(k);
            if ((k % 2) == 1) begin
                e1 = e1 - term;
            end else begin
                e1 = e1 + term;
            end
        end
        rom[0] = 32'hffff_ffff;
        f = e1;
        for (int n = 1; n < ROM_SIZE; n++) begin
            t = f >> 32;
            if (((f & 64'h0000_0000_ffff_ffff) << 32) < f) begin
                t = t - 64'd1;
            end
            rom[n] = t[HALF_W-1:0];
            prod   = {64'd0, f} * {64'd0, e1};
            f      = prod[127:64];
        end
        return rom;
    endfunction

    localparam t_thr_rom THR_ROM = build_thr_rom();

endpackage

// ----- rtl/sgsu_ram.sv -----
// Generic simple dual-port RAM with registered, read-first read port.
module sgsu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, holds its data when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/stochastic_gene_site_update.sv -----
// Top level: per-row xorshift128+ generators in RAM, popcount-threshold survival draws.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+----------------------------------------
//  input   | i_valid | o_stall | i_opcode, i_row, i_data_word
//  output  | o_valid | i_stall | o_next_alive, o_next_gene
//
// One beat per cycle sustained while the output is not stalled, seeds and updates
// alike; same-row updates may follow each other in consecutive cycles.
// An update beat accepted on the input reaches the output through stage 1
// (RAM read, generator step and write-back), stage 2 (threshold compare) and the output register.
// The read-modify-write loop on the two generator RAMs closes in stage 1; the
// word written back at an edge is forwarded to a read of the same row at that edge.
// Reset clears pipeline control only; generator RAM contents are unknown until seeded.
// Output stall backs up through the pipeline; a seed beat in stage 1 never waits on the output.
module stochastic_gene_site_update
    import sgsu_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [ROW_IN_W-1:0] i_row,
    input  logic [WORD_W-1:0]   i_data_word,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [ALIVE_W-1:0]  o_next_alive,
    output logic [WORD_W-1:0]   o_next_gene
);

    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Row reduction table, row modulo ROWS
    logic [ROW_AW-1:0] row_map [0:ROW_IN_N-1];
    for (genvar g = 0; g < ROW_IN_N; g++) begin : g_row_map
        assign row_map[g] = ROW_AW'(g % ROWS);
    end

    // Handshake and pipeline control
    logic              accept;
    logic              s1_fire;
    logic              s1_upd;
    logic              s2_free;
    logic              s2_load;
    logic              out_free;
    logic [ROW_AW-1:0] in_row;

    // Stage 1 registers (RAM read in flight)
    logic              r_s1_valid;
    logic [OP_W-1:0]   r_s1_op;
    logic [ROW_AW-1:0] r_s1_row;
    logic [WORD_W-1:0] r_s1_data;
    logic [CNT_W-1:0]  r_s1_cnt_lo;
    logic [CNT_W-1:0]  r_s1_cnt_hi;

    // Forwarding of the write that coincided with the stage 1 read
    logic              r_fwd_w0_hit;
    logic              r_fwd_w1_hit;
    logic [WORD_W-1:0] r_fwd_w0;
    logic [WORD_W-1:0] r_fwd_w1;

    // Stage 2 registers
    logic              r_s2_valid;
    logic [WORD_W-1:0] r_s2_rnd;
    logic [CNT_W-1:0]  r_s2_cnt_lo;
    logic [CNT_W-1:0]  r_s2_cnt_hi;

    // Output register
    logic               r_out_valid;
    logic [ALIVE_W-1:0] r_out_alive;
    logic [WORD_W-1:0]  r_out_gene;

    // RAM ports
    logic              we0;
    logic              we1;
    logic [WORD_W-1:0] wdata0;
    logic [WORD_W-1:0] wdata1;
    logic [WORD_W-1:0] q0;
    logic [WORD_W-1:0] q1;

    // Generator step
    logic [WORD_W-1:0]  gen_x;
    logic [WORD_W-1:0]  gen_y;
    logic [WORD_W-1:0]  gen_xs;
    logic [WORD_W-1:0]  gen_w1;
    logic [WORD_W-1:0]  gen_rnd;
    logic [ALIVE_W-1:0] n_alive;

    // Flow control
    assign out_free = !r_out_valid || !i_stall;
    assign s2_load  = r_s2_valid && out_free;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_upd   = (r_s1_op == OP_UPDATE);
    assign s1_fire  = r_s1_valid && (!s1_upd || s2_free);
    assign o_stall  = r_s1_valid && !s1_fire;
    assign accept   = i_valid && !o_stall;
    assign in_row   = row_map[i_row];

    // Generator RAMs: word zero and word one of each row
    sgsu_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_ram_w0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (r_s1_row),
        .i_wdata (wdata0),
        .i_re    (accept),
        .i_raddr (in_row),
        .o_rdata (q0)
    );

    sgsu_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_ram_w1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_s1_row),
        .i_wdata (wdata1),
        .i_re    (accept),
        .i_raddr (in_row),
        .o_rdata (q1)
    );

    // Stage 1: forwarded state, step, write-back
    always_comb begin
        gen_x   = r_fwd_w0_hit ? r_fwd_w0 : q0;
        gen_y   = r_fwd_w1_hit ? r_fwd_w1 : q1;
        gen_xs  = gen_x ^ (gen_x << SH_A);
        gen_w1  = gen_xs ^ gen_y ^ (gen_xs >> SH_B) ^ (gen_y >> SH_C);
        gen_rnd = gen_w1 + gen_y;
        we0     = s1_fire && (s1_upd || (r_s1_op == OP_WR_W0));
        we1     = s1_fire && (s1_upd || (r_s1_op == OP_WR_W1));
        wdata0  = s1_upd ? gen_y  : r_s1_data;
        wdata1  = s1_upd ? gen_w1 : r_s1_data;
    end

    // Stage 2: threshold compare per half
    always_comb begin
        n_alive[0] = r_s2_rnd[HALF_W-1:0]      < THR_ROM[r_s2_cnt_lo];
        n_alive[1] = r_s2_rnd[WORD_W-1:HALF_W] < THR_ROM[r_s2_cnt_hi];
    end

    // Input capture and forwarding capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_fwd_w0_hit <= 1'b0;
            r_fwd_w1_hit <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid   <= 1'b1;
                r_fwd_w0_hit <= we0 && (r_s1_row == in_row);
                r_fwd_w1_hit <= we1 && (r_s1_row == in_row);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op     <= i_opcode;
            r_s1_row    <= in_row;
            r_s1_data   <= i_data_word;
            r_s1_cnt_lo <= CNT_W'($countones(i_data_word[HALF_W-1:0]));
            r_s1_cnt_hi <= CNT_W'($countones(i_data_word[WORD_W-1:HALF_W]));
            r_fwd_w0    <= wdata0;
            r_fwd_w1    <= wdata1;
        end
    end

    // Stage 2 and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_fire && s1_upd) begin
                r_s2_valid <= 1'b1;
            end else if (s2_load) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_upd) begin
            r_s2_rnd    <= gen_rnd;
            r_s2_cnt_lo <= r_s1_cnt_lo;
            r_s2_cnt_hi <= r_s1_cnt_hi;
        end
        if (s2_load) begin
            r_out_alive <= n_alive;
            r_out_gene  <= r_s2_rnd;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_next_alive = r_out_alive;
    assign o_next_gene  = r_out_gene;

    // Checks
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted beat did not reach stage 1");

    a_update_reaches_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_upd) |=> r_s2_valid)
        else $error("update beat lost between stage 1 and stage 2");

    a_stall_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && s1_upd && r_s2_valid && r_out_valid && i_stall))
        else $error("input stalled without a full pipeline");

    a_s2_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load |=> o_valid)
        else $error("stage 2 result did not reach the output register");

endmodule
